@@ src/quoted_op_spelling_scanner_macros.svh @@
// assertion helpers for the quoted op spelling scanner
`ifndef QUOTED_OP_SPELLING_SCANNER_MACROS_SVH
`define QUOTED_OP_SPELLING_SCANNER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define QOSS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define QOSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define QOSS_ASSERT_NOW(label, ante, cons)
`define QOSS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ src/qoss_pkg.sv @@
package qoss_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} qoss_in_t;

	typedef struct packed {
		logic generic_op_found;
		logic bytecode_header;
		logic reject_message;
	} qoss_out_t;

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_NL     = 8'h0A;

	localparam logic [2:0] HDR_LEN    = 3'd4;
	localparam logic [1:0] PREFIX_LEN = 2'd3;

	function automatic logic [7:0] prefix_char(input logic [1:0] pos);
		logic [7:0] ch;
		case (pos)
			2'd0:    ch = 8'h61;
			2'd1:    ch = 8'h63;
			2'd2:    ch = 8'h2E;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] magic_char(input logic [1:0] pos);
		logic [7:0] ch;
		case (pos)
			2'd0:    ch = 8'h4D;
			2'd1:    ch = 8'h4C;
			2'd2:    ch = 8'hEF;
			default: ch = 8'h52;
		endcase
		return ch;
	endfunction

endpackage

@@ src/quoted_op_spelling_scanner.sv @@
// Quoted op spelling scanner.
// Input channel (in_valid/in_ready/in_data) carries one message byte per word,
// with last_byte marking the end of a message. Output channel
// (out_valid/out_ready/out_data) carries one result word per message: found,
// bytecode header and reject.
// Each accepted byte is held in an input register and the scan state is
// updated from that register; the result of a message is registered into
// out_data when its last byte leaves the input register.
// Throughput is one byte per cycle, but a last byte waits while a result is held.
// After the last byte the scan state returns to its reset values, so the next
// byte starts a new message.
// Reset clears the scan state and both valid flags; no word is pending.
// A stalled receiver holds the result register; further non-last bytes keep
// flowing, and the next last byte waits in the input register until the
// result register is free.
`include "quoted_op_spelling_scanner_macros.svh"

module quoted_op_spelling_scanner (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  qoss_pkg::qoss_in_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output qoss_pkg::qoss_out_t out_data
);
	import qoss_pkg::*;

	typedef enum logic [5:0] {
		M_NORMAL = 6'b000001,
		M_SLASH  = 6'b000010,
		M_LINE   = 6'b000100,
		M_BLOCK  = 6'b001000,
		M_STRING = 6'b010000,
		M_AFTER  = 6'b100000
	} mode_t;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;

	mode_t      mode_q, mode_d;
	logic       star_q, star_d;
	logic       esc_q, esc_d;
	logic [1:0] pos_q, pos_d;
	logic       pmatch_q, pmatch_d;
	logic       found_q, found_d;
	logic [2:0] hdr_cnt_q, hdr_cnt_d;
	logic       magic_q, magic_d;

	logic      out_valid_q;
	qoss_out_t out_data_q;
	qoss_out_t result;

	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_data.data_byte;
			last_s1 <= in_data.last_byte;
		end
	end

	always_comb begin
		logic [7:0] c;
		logic       plain;
		c         = byte_s1;
		plain     = 1'b0;
		mode_d    = mode_q;
		star_d    = star_q;
		esc_d     = esc_q;
		pos_d     = pos_q;
		pmatch_d  = pmatch_q;
		found_d   = found_q;
		hdr_cnt_d = hdr_cnt_q;
		magic_d   = magic_q;

		if (hdr_cnt_q < HDR_LEN) begin
			if (c != magic_char(hdr_cnt_q[1:0])) begin
				magic_d = 1'b0;
			end
			hdr_cnt_d = hdr_cnt_q + 3'd1;
		end

		case (mode_q)
			M_SLASH: begin
				if (c == CH_SLASH) begin
					mode_d = M_LINE;
				end else if (c == CH_STAR) begin
					mode_d = M_BLOCK;
					star_d = 1'b0;
				end else begin
					plain = 1'b1;
				end
			end
			M_LINE: begin
				if (c == CH_NL) begin
					mode_d = M_NORMAL;
				end
			end
			M_BLOCK: begin
				if (star_q && c == CH_SLASH) begin
					mode_d = M_NORMAL;
				end
				star_d = (c == CH_STAR);
			end
			M_STRING: begin
				if (!esc_q && c == CH_QUOTE) begin
					mode_d = (pmatch_q && pos_q == PREFIX_LEN) ? M_AFTER : M_NORMAL;
				end else begin
					if (pos_q < PREFIX_LEN) begin
						if (c != prefix_char(pos_q)) begin
							pmatch_d = 1'b0;
						end
						pos_d = pos_q + 2'd1;
					end
					esc_d = !esc_q && c == CH_BSLASH;
				end
			end
			M_AFTER: begin
				if (c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D}) begin
					mode_d = M_AFTER;
				end else if (c == CH_LPAREN) begin
					found_d = 1'b1;
					mode_d  = M_NORMAL;
				end else begin
					plain = 1'b1;
				end
			end
			default: begin
				plain = 1'b1;
			end
		endcase

		if (plain) begin
			if (c == CH_SLASH) begin
				mode_d = M_SLASH;
			end else if (c == CH_QUOTE) begin
				mode_d   = M_STRING;
				esc_d    = 1'b0;
				pos_d    = 2'd0;
				pmatch_d = 1'b1;
			end else begin
				mode_d = M_NORMAL;
			end
		end

		result.generic_op_found = found_d;
		result.bytecode_header  = (hdr_cnt_d >= HDR_LEN) && magic_d;
		result.reject_message   = found_d && !result.bytecode_header;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_NORMAL;
			star_q    <= 1'b0;
			esc_q     <= 1'b0;
			pos_q     <= 2'd0;
			pmatch_q  <= 1'b1;
			found_q   <= 1'b0;
			hdr_cnt_q <= 3'd0;
			magic_q   <= 1'b1;
		end else if (advance) begin
			if (last_s1) begin
				mode_q    <= M_NORMAL;
				star_q    <= 1'b0;
				esc_q     <= 1'b0;
				pos_q     <= 2'd0;
				pmatch_q  <= 1'b1;
				found_q   <= 1'b0;
				hdr_cnt_q <= 3'd0;
				magic_q   <= 1'b1;
			end else begin
				mode_q    <= mode_d;
				star_q    <= star_d;
				esc_q     <= esc_d;
				pos_q     <= pos_d;
				pmatch_q  <= pmatch_d;
				found_q   <= found_d;
				hdr_cnt_q <= hdr_cnt_d;
				magic_q   <= magic_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// a result never overwrites one still waiting
	`QOSS_ASSERT_NOW(a_no_overrun, advance && last_s1 && out_valid_q, out_ready)
	// end of message returns the scan state to its start
	`QOSS_ASSERT_NEXT(a_restart, advance && last_s1,
		mode_q == M_NORMAL && hdr_cnt_q == 3'd0 && !found_q && magic_q)
	// reject only with a find and no bytecode header
	`QOSS_ASSERT_NOW(a_reject, out_valid_q,
		out_data_q.reject_message ==
		(out_data_q.generic_op_found && !out_data_q.bytecode_header))
	// the header count saturates
	`QOSS_ASSERT_NOW(a_hdr_sat, valid_s1, hdr_cnt_q <= HDR_LEN)

endmodule

@@ dv/quoted_op_spelling_scanner_test.sv @@
module quoted_op_spelling_scanner_test;
	timeunit 1ns;
	timeprecision 1ps;

	import qoss_pkg::*;

	typedef enum logic [2:0] {
		SC_TEXT,
		SC_SLASH,
		SC_LINE,
		SC_BLOCK,
		SC_STRING,
		SC_AFTER
	} scan_mode_e;

	typedef struct packed {
		logic [7:0] c;
		logic       last;
		logic       typed;
		qoss_out_t  want;
	} row_t;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] SPELL [3] = '{8'h61, 8'h63, 8'h2E};
	localparam logic [7:0] MAGIC [4] = '{8'h4D, 8'h4C, 8'hEF, 8'h52};
	localparam int         N_HOT = 12;
	localparam logic [7:0] HOT_BYTES [N_HOT] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_STAR,
		CH_LPAREN, CH_SPACE, CH_NL, CH_TAB, 8'h61, 8'h63, 8'h2E, 8'h4D};
	localparam int         N_DIRECTED = 23;
	localparam int         N_WORDS = 1725;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	qoss_in_t  in_data;
	logic      out_valid;
	logic      out_ready;
	qoss_out_t out_data;

	// typed expectation travelling alongside the current input word
	logic      in_typed;
	qoss_out_t in_want;

	scan_mode_e mode;
	logic       star;
	logic       esc;
	logic [1:0] spell_pos;
	logic       spell_ok;
	logic       found;
	logic [2:0] hdr_cnt;
	logic       magic_ok;

	qoss_out_t verdicts_due[$];
	row_t      words[$];
	int        errors = 0;
	int        verdicts_seen = 0;
	int        found_seen = 0;
	int        bytes_in = 0;
	int        send_idle = 32;
	int        recv_stall = 78;

	row_t directed_rows [N_DIRECTED] = '{
		{MAGIC[0], 1'b0, 1'b0, 3'b000},
		{MAGIC[1], 1'b0, 1'b0, 3'b000},
		{MAGIC[2], 1'b0, 1'b0, 3'b000},
		{MAGIC[3], 1'b1, 1'b1, 3'b010},
		{8'hFF, 1'b1, 1'b1, 3'b000},
		{CH_QUOTE, 1'b0, 1'b0, 3'b000},
		{SPELL[0], 1'b0, 1'b0, 3'b000},
		{SPELL[1], 1'b0, 1'b0, 3'b000},
		{SPELL[2], 1'b0, 1'b0, 3'b000},
		{CH_QUOTE, 1'b0, 1'b0, 3'b000},
		{CH_SPACE, 1'b0, 1'b0, 3'b000},
		{CH_LPAREN, 1'b1, 1'b1, 3'b101},
		{CH_SLASH, 1'b0, 1'b0, 3'b000},
		{CH_STAR, 1'b0, 1'b0, 3'b000},
		{CH_SLASH, 1'b1, 1'b0, 3'b000},
		{CH_SLASH, 1'b0, 1'b0, 3'b000},
		{CH_QUOTE, 1'b0, 1'b0, 3'b000},
		{SPELL[0], 1'b0, 1'b0, 3'b000},
		{SPELL[1], 1'b0, 1'b0, 3'b000},
		{SPELL[2], 1'b0, 1'b0, 3'b000},
		{CH_QUOTE, 1'b0, 1'b0, 3'b000},
		{CH_LPAREN, 1'b1, 1'b0, 3'b000},
		{8'h00, 1'b1, 1'b1, 3'b000}
	};

	quoted_op_spelling_scanner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic flag_mismatch(input string what);
		errors++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	task automatic check_bit(input string field, input logic got, input logic want);
		if (got !== want)
			flag_mismatch($sformatf("%s got %b want %b", field, got, want));
	endtask

	task automatic clear_scan();
		mode = SC_TEXT;
		star = 1'b0;
		esc = 1'b0;
		spell_pos = '0;
		spell_ok = 1'b1;
		found = 1'b0;
		hdr_cnt = '0;
		magic_ok = 1'b1;
	endtask

	task automatic plain_text(input logic [7:0] c);
		if (c == CH_SLASH) begin
			mode = SC_SLASH;
		end else if (c == CH_QUOTE) begin
			mode = SC_STRING;
			esc = 1'b0;
			spell_pos = '0;
			spell_ok = 1'b1;
		end else begin
			mode = SC_TEXT;
		end
	endtask

	task automatic scan_word(input logic [7:0] c, input logic last, output bit done,
		output qoss_out_t res);
		logic bytecode;
		if (hdr_cnt < HDR_LEN) begin
			if (c != MAGIC[hdr_cnt[1:0]])
				magic_ok = 1'b0;
			hdr_cnt++;
		end
		case (mode)
			SC_SLASH: begin
				if (c == CH_SLASH) begin
					mode = SC_LINE;
				end else if (c == CH_STAR) begin
					mode = SC_BLOCK;
					star = 1'b0;
				end else begin
					plain_text(c);
				end
			end
			SC_LINE: begin
				if (c == CH_NL)
					mode = SC_TEXT;
			end
			SC_BLOCK: begin
				if (star && c == CH_SLASH)
					mode = SC_TEXT;
				star = (c == CH_STAR);
			end
			SC_STRING: begin
				if (!esc && c == CH_QUOTE) begin
					mode = (spell_ok && spell_pos == PREFIX_LEN) ? SC_AFTER : SC_TEXT;
				end else begin
					if (spell_pos < PREFIX_LEN) begin
						if (c != SPELL[spell_pos])
							spell_ok = 1'b0;
						spell_pos++;
					end
					esc = !esc && c == CH_BSLASH;
				end
			end
			SC_AFTER: begin
				if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
					mode = SC_AFTER;
				end else if (c == CH_LPAREN) begin
					found = 1'b1;
					mode = SC_TEXT;
				end else begin
					plain_text(c);
				end
			end
			default: plain_text(c);
		endcase
		bytecode = hdr_cnt >= HDR_LEN && magic_ok;
		res.generic_op_found = found;
		res.bytecode_header = bytecode;
		res.reject_message = found && !bytecode;
		done = last;
		if (last)
			clear_scan();
	endtask

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(1))
			return HOT_BYTES[$urandom_range(N_HOT - 1)];
		return 8'($urandom_range(255));
	endfunction

	task automatic add_message();
		logic [7:0] msg[$];
		row_t r;
		if ($urandom_range(9) < 2) begin
			repeat ($urandom_range(1, 8)) msg.push_back(pick_byte());
		end else begin
			if ($urandom_range(9) < 3) begin
				foreach (MAGIC[k]) msg.push_back(MAGIC[k]);
				if ($urandom_range(3) == 0)
					msg[$urandom_range(3)] = pick_byte();
			end
			repeat ($urandom_range(1, 4)) begin
				case ($urandom_range(4))
					0: begin
						msg.push_back(CH_QUOTE);
						if ($urandom_range(9) < 7) begin
							foreach (SPELL[k]) msg.push_back(SPELL[k]);
							if ($urandom_range(4) == 0)
								msg[msg.size() - 1 - $urandom_range(2)] = pick_byte();
						end
						repeat ($urandom_range(0, 3)) begin
							case ($urandom_range(2))
								0: begin
									msg.push_back(CH_BSLASH);
									msg.push_back(CH_QUOTE);
								end
								1: begin
									msg.push_back(CH_BSLASH);
									msg.push_back(CH_BSLASH);
								end
								default: msg.push_back(pick_byte());
							endcase
						end
						if ($urandom_range(9) != 0)
							msg.push_back(CH_QUOTE);
						repeat ($urandom_range(0, 2))
							msg.push_back($urandom_range(1) ? CH_SPACE :
								8'($urandom_range(CH_TAB, CH_CR)));
						msg.push_back($urandom_range(9) < 7 ? CH_LPAREN : pick_byte());
					end
					1: begin
						msg.push_back(CH_SLASH);
						msg.push_back(CH_SLASH);
						repeat ($urandom_range(0, 4)) msg.push_back(pick_byte());
						if ($urandom_range(9) < 7)
							msg.push_back(CH_NL);
					end
					2: begin
						msg.push_back(CH_SLASH);
						msg.push_back(CH_STAR);
						if ($urandom_range(9) < 3)
							msg.push_back(CH_SLASH);
						repeat ($urandom_range(0, 4)) msg.push_back(pick_byte());
						if ($urandom_range(9) < 7) begin
							msg.push_back(CH_STAR);
							msg.push_back(CH_SLASH);
						end
					end
					3: repeat ($urandom_range(1, 4)) msg.push_back(8'($urandom_range(255)));
					default: begin
						msg.push_back(CH_SLASH);
						msg.push_back(pick_byte());
					end
				endcase
			end
		end
		foreach (msg[k]) begin
			r.c = msg[k];
			r.last = (k == msg.size() - 1);
			r.typed = 1'b0;
			r.want = '0;
			words.push_back(r);
		end
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall);

	always @(posedge clk) begin : monitor
		qoss_out_t want;
		qoss_out_t pred;
		bit done;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (verdicts_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected result word %b", out_data));
				end else begin
					want = verdicts_due.pop_front();
					check_bit("generic_op_found", out_data.generic_op_found,
						want.generic_op_found);
					check_bit("bytecode_header", out_data.bytecode_header,
						want.bytecode_header);
					check_bit("reject_message", out_data.reject_message,
						want.reject_message);
					verdicts_seen++;
					if (want.generic_op_found)
						found_seen++;
				end
			end
			if (in_valid && in_ready) begin
				bytes_in++;
				scan_word(in_data.data_byte, in_data.last_byte, done, pred);
				if (done)
					verdicts_due.push_back(in_typed ? in_want : pred);
			end
		end
	end

	initial begin
		qoss_in_t w;
		int n;
		clear_scan();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		in_typed = 1'b0;
		in_want = '0;
		out_ready = 1'b0;
		foreach (directed_rows[k]) words.push_back(directed_rows[k]);
		while (words.size() < N_WORDS)
			add_message();
		n = words.size();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int i = 0; i < n; i++) begin
			if (i == n / 3) begin
				send_idle = 78;
				recv_stall = 32;
			end else if (i == 2 * n / 3) begin
				send_idle = 0;
				recv_stall = 0;
			end
			while ($urandom_range(99) < send_idle) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
			w.data_byte = words[i].c;
			w.last_byte = words[i].last;
			in_valid <= 1'b1;
			in_data <= w;
			in_typed <= words[i].typed;
			in_want <= words[i].want;
			@(posedge clk);
			while (!in_ready) @(posedge clk);
			@(negedge clk);
		end
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("%0d bytes scanned over %0d messages, %0d with a quoted op spelling found",
			bytes_in, verdicts_seen, found_seen);
		$display("idle mixes: sender-heavy, receiver-heavy and none; %0d mismatches", errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", verdicts_due.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+src
src/qoss_pkg.sv
src/quoted_op_spelling_scanner.sv
dv/quoted_op_spelling_scanner_test.sv
